FILE: rtl/sliding_window_event_assigner_core_macros.svh
// assertion macros for the sliding window event assigner
`ifndef SLIDING_WINDOW_EVENT_ASSIGNER_CORE_MACROS_SVH
`define SLIDING_WINDOW_EVENT_ASSIGNER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SWEA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SWEA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/swea_pkg.sv
// shared types, constants and register codes for the sliding window event assigner
`timescale 1ns / 1ps

package swea_pkg;

	localparam int TIME_W = 31;
	localparam int REF_W = 32;
	localparam int TAG_W = 31;
	localparam int RANK_CNT_W = 9;
	localparam int RANK_W = 8;
	localparam int MAX_WINDOWS_PER_EVENT = 32;
	localparam int CNT_W = $clog2(MAX_WINDOWS_PER_EVENT + 1);
	localparam int DIV_W = 31;
	localparam int DIV_STEP_W = $clog2(DIV_W);
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [RANK_CNT_W-1:0] RANK_LIMIT = RANK_CNT_W'(256);

	// register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_SLIDE = 2'd0;
	localparam logic [1:0] REG_RANGE = 2'd1;
	localparam logic [1:0] REG_RANKS = 2'd2;

	localparam logic KIND_ASSIGN = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] evt_stamp;
		logic [REF_W-1:0] event_ref;
		logic [TAG_W-1:0] message_tag;
		logic end_of_message;
	} evt_item_t;

	typedef struct packed {
		logic result_kind;
		logic [TIME_W-1:0] window_id;
		logic [RANK_W-1:0] target_rank;
		logic [REF_W-1:0] out_event_ref;
		logic [TAG_W-1:0] out_message_tag;
		logic [TIME_W-1:0] span_low;
		logic [TIME_W-1:0] span_high;
		logic last;
	} res_item_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

endpackage

FILE: rtl/swea_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module swea_div (
	input  logic               clk,
	input  logic               arst_n,
	input  swea_pkg::div_req_t req,
	output swea_pkg::div_rsp_t rsp
);

	localparam logic [swea_pkg::DIV_STEP_W-1:0] LAST_STEP =
		swea_pkg::DIV_STEP_W'(swea_pkg::DIV_W - 1);

	logic [swea_pkg::DIV_W-1:0] rem_q;
	logic [swea_pkg::DIV_W-1:0] quo_q;
	logic [swea_pkg::DIV_W-1:0] dsr_q;
	logic [swea_pkg::DIV_STEP_W-1:0] step_q;
	logic busy_q;
	logic done_q;

	logic [swea_pkg::DIV_W:0] shifted;
	logic [swea_pkg::DIV_W:0] diff;
	logic ge;

	always_comb begin
		shifted = {rem_q, quo_q[swea_pkg::DIV_W-1]};
		diff = shifted - {1'b0, dsr_q};
		ge = shifted >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && (step_q == LAST_STEP);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[swea_pkg::DIV_W-1:0] : shifted[swea_pkg::DIV_W-1:0];
			quo_q <= {quo_q[swea_pkg::DIV_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem = rem_q;

endmodule

FILE: rtl/sliding_window_event_assigner_core.sv
// sliding window event assigner top level: sequencer, span tracking, result register
// per event: divisions for the newest window and the window count, then one for the rank
// unless the event has no window or the rank count is zero; up to 33 results per event
// a new event is accepted only in idle, after the last result of the previous one is loaded
// reset: registers go to slide 1, range 1, ranks 1; span low all ones, span high 0
`timescale 1ns / 1ps

`include "sliding_window_event_assigner_core_macros.svh"

module sliding_window_event_assigner_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              evt_valid,
	output logic                              evt_ready,
	input  swea_pkg::evt_item_t               evt,
	output logic                              res_valid,
	input  logic                              res_ready,
	output swea_pkg::res_item_t               res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [swea_pkg::ADDR_W-1:0]       paddr,
	input  logic [swea_pkg::DATA_W-1:0]       pwdata,
	output logic [swea_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_DIV_NEW  = 7'b0000010,
		ST_DIV_CNT  = 7'b0000100,
		ST_SPAN     = 7'b0001000,
		ST_DIV_RANK = 7'b0010000,
		ST_EMIT     = 7'b0100000,
		ST_SUMM     = 7'b1000000
	} state_t;

	localparam logic [swea_pkg::DIV_W-1:0] MAX_WIN =
		swea_pkg::DIV_W'(swea_pkg::MAX_WINDOWS_PER_EVENT);

	state_t state_q;

	logic [swea_pkg::TIME_W-1:0] slide_q;
	logic [swea_pkg::TIME_W-1:0] range_q;
	logic [swea_pkg::RANK_CNT_W-1:0] rank_cnt_q;

	logic [swea_pkg::TIME_W-1:0] low_q;
	logic [swea_pkg::TIME_W-1:0] high_q;

	logic [swea_pkg::TIME_W-1:0] newest_q;
	logic [swea_pkg::CNT_W-1:0] cnt_q;
	logic [swea_pkg::TIME_W-1:0] w_q;
	logic [swea_pkg::RANK_W-1:0] rank_q;
	logic [swea_pkg::REF_W-1:0] ref_q;
	logic [swea_pkg::TAG_W-1:0] tag_q;
	logic eom_q;

	swea_pkg::res_item_t res_q;
	logic res_valid_q;

	swea_pkg::div_req_t div_req;
	swea_pkg::div_rsp_t div_rsp;

	logic [swea_pkg::TIME_W-1:0] slide_eff;
	logic [swea_pkg::RANK_CNT_W-1:0] ranks_eff;
	logic accept;
	logic slot_free;
	logic load_asg;
	logic load_sum;
	logic at_newest;
	logic cfg_wr;
	logic [swea_pkg::TIME_W-1:0] back_w;
	logic [swea_pkg::TIME_W-1:0] clip_w;
	logic [swea_pkg::TIME_W-1:0] oldest;
	logic [swea_pkg::RANK_CNT_W-1:0] rank_inc;
	logic [swea_pkg::RANK_W-1:0] rank_nxt;

	swea_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		slide_eff = (slide_q == '0) ? swea_pkg::TIME_W'(1) : slide_q;
		ranks_eff = (rank_cnt_q > swea_pkg::RANK_LIMIT) ? swea_pkg::RANK_LIMIT : rank_cnt_q;
		accept = evt_valid && evt_ready;
		slot_free = !res_valid_q || res_ready;
		load_asg = (state_q == ST_EMIT) && slot_free;
		load_sum = (state_q == ST_SUMM) && slot_free;
		at_newest = w_q == newest_q;
		cfg_wr = psel && penable && pwrite;
		back_w = swea_pkg::TIME_W'(cnt_q - 1'b1);
		clip_w = (back_w < newest_q) ? back_w : newest_q;
		oldest = newest_q - clip_w;
		rank_inc = {1'b0, rank_q} + 1'b1;
		rank_nxt = ((ranks_eff == '0) || (rank_inc == ranks_eff)) ? '0
			: rank_inc[swea_pkg::RANK_W-1:0];
	end

	always_comb begin
		div_req = '0;
		case (state_q)
			ST_IDLE: begin
				div_req.start = accept;
				div_req.dividend = evt.evt_stamp;
				div_req.divisor = slide_eff;
			end
			ST_DIV_NEW: begin
				div_req.start = div_rsp.done;
				div_req.dividend = range_q;
				div_req.divisor = slide_eff;
			end
			ST_SPAN: begin
				div_req.start = (cnt_q != '0) && (ranks_eff != '0);
				div_req.dividend = oldest;
				div_req.divisor = swea_pkg::DIV_W'(ranks_eff);
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	assign evt_ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
			low_q <= '1;
			high_q <= '0;
			slide_q <= swea_pkg::TIME_W'(1);
			range_q <= swea_pkg::TIME_W'(1);
			rank_cnt_q <= swea_pkg::RANK_CNT_W'(1);
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					swea_pkg::REG_SLIDE: slide_q <= pwdata[swea_pkg::TIME_W-1:0];
					swea_pkg::REG_RANGE: range_q <= pwdata[swea_pkg::TIME_W-1:0];
					swea_pkg::REG_RANKS: rank_cnt_q <= pwdata[swea_pkg::RANK_CNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (load_asg || load_sum) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV_NEW;
					end
				end
				ST_DIV_NEW: begin
					if (div_rsp.done) begin
						state_q <= ST_DIV_CNT;
					end
				end
				ST_DIV_CNT: begin
					if (div_rsp.done) begin
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: begin
					if (cnt_q == '0) begin
						state_q <= eom_q ? ST_SUMM : ST_IDLE;
					end else begin
						if (newest_q > high_q) begin
							high_q <= newest_q;
						end
						if (oldest < low_q) begin
							low_q <= oldest;
						end
						state_q <= (ranks_eff != '0) ? ST_DIV_RANK : ST_EMIT;
					end
				end
				ST_DIV_RANK: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_asg && at_newest) begin
						state_q <= eom_q ? ST_SUMM : ST_IDLE;
					end
				end
				ST_SUMM: begin
					if (load_sum) begin
						low_q <= '1;
						high_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ref_q <= evt.event_ref;
			tag_q <= evt.message_tag;
			eom_q <= evt.end_of_message;
		end
		if ((state_q == ST_DIV_NEW) && div_rsp.done) begin
			newest_q <= div_rsp.quot;
		end
		if ((state_q == ST_DIV_CNT) && div_rsp.done) begin
			cnt_q <= (div_rsp.quot > MAX_WIN) ? swea_pkg::CNT_W'(swea_pkg::MAX_WINDOWS_PER_EVENT)
				: div_rsp.quot[swea_pkg::CNT_W-1:0];
		end
		if (state_q == ST_SPAN) begin
			w_q <= oldest;
			rank_q <= '0;
		end
		if ((state_q == ST_DIV_RANK) && div_rsp.done) begin
			rank_q <= div_rsp.rem[swea_pkg::RANK_W-1:0];
		end
		if (load_asg) begin
			res_q.result_kind <= swea_pkg::KIND_ASSIGN;
			res_q.window_id <= w_q;
			res_q.target_rank <= rank_q;
			res_q.out_event_ref <= ref_q;
			res_q.out_message_tag <= tag_q;
			res_q.span_low <= '0;
			res_q.span_high <= '0;
			res_q.last <= at_newest && !eom_q;
			if (!at_newest) begin
				w_q <= w_q + 1'b1;
				rank_q <= rank_nxt;
			end
		end
		if (load_sum) begin
			res_q.result_kind <= swea_pkg::KIND_SUMMARY;
			res_q.window_id <= '0;
			res_q.target_rank <= '0;
			res_q.out_event_ref <= '0;
			res_q.out_message_tag <= tag_q;
			res_q.span_low <= low_q;
			res_q.span_high <= high_q;
			res_q.last <= 1'b1;
		end
	end

	always_comb begin
		case (paddr[3:2])
			swea_pkg::REG_SLIDE: prdata = swea_pkg::DATA_W'(slide_q);
			swea_pkg::REG_RANGE: prdata = swea_pkg::DATA_W'(range_q);
			swea_pkg::REG_RANKS: prdata = swea_pkg::DATA_W'(rank_cnt_q);
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign res_valid = res_valid_q;
	assign res = res_q;

	`SWEA_ASSERT_NEXT(a_accept_starts_div, accept, div_rsp.busy, "divider idle after transfer")
	`SWEA_ASSERT_NOW(a_summary_last, res_valid && (res.result_kind == swea_pkg::KIND_SUMMARY), res.last, "summary without last")
	`SWEA_ASSERT_NOW(a_rank_bound, res_valid && (res.result_kind == swea_pkg::KIND_ASSIGN) && (ranks_eff != '0), {1'b0, res.target_rank} < ranks_eff, "target rank out of range")

endmodule

FILE: bench/sliding_window_event_assigner_core_tb.sv
// testbench for the sliding window event assigner: directed table, random messages, predictor check
`timescale 1ns / 1ps

module sliding_window_event_assigner_core_tb;

	typedef logic [swea_pkg::TIME_W-1:0] stamp_t;
	typedef logic [swea_pkg::TAG_W-1:0] tag_t;
	typedef logic [swea_pkg::RANK_CNT_W-1:0] rcnt_t;
	typedef logic [swea_pkg::RANK_W-1:0] rank_t;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 200;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_EVENTS = 60;
	localparam int HOLD_AT = 100;
	localparam int HOLD_CYCLES = 2000;
	localparam int EXP_DEPTH = 32768;
	localparam int STEP_MAX = swea_pkg::MAX_WINDOWS_PER_EVENT + 1;
	localparam int PLAN_MAX = 64;
	localparam stamp_t T_MAX = '1;
	localparam stamp_t SPAN_LOW_RESET = '1;

	typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_TYPED} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		stamp_t slide;
		stamp_t win_range;
		rcnt_t ranks;
		swea_pkg::evt_item_t ev;
		logic has_win;
		stamp_t win;
		rank_t rank;
		stamp_t lo;
		stamp_t hi;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_ready;
	swea_pkg::evt_item_t evt = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	swea_pkg::res_item_t res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [swea_pkg::ADDR_W-1:0] paddr = '0;
	logic [swea_pkg::DATA_W-1:0] pwdata = '0;
	logic [swea_pkg::DATA_W-1:0] prdata;
	logic pready;

	stamp_t cfg_slide = stamp_t'(1);
	stamp_t cfg_range = stamp_t'(1);
	rcnt_t cfg_ranks = rcnt_t'(1);
	stamp_t span_lo = SPAN_LOW_RESET;
	stamp_t span_hi = '0;

	swea_pkg::res_item_t step_res[STEP_MAX];
	int step_n = 0;
	swea_pkg::res_item_t expected_res[EXP_DEPTH];
	int exp_wr = 0;
	int exp_rd = 0;
	plan_row_t plan[PLAN_MAX];
	int n_plan = 0;

	int n_events = 0;
	int n_checked = 0;
	int n_summaries = 0;
	int n_settings = 0;
	int mismatches = 0;
	int cycles = 0;
	bit tx_calm = 1'b0;

	sliding_window_event_assigner_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt(evt),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic swea_pkg::evt_item_t mk_evt(input stamp_t t,
			input logic [swea_pkg::REF_W-1:0] handle, input tag_t tag, input logic eom);
		swea_pkg::evt_item_t e;
		e.evt_stamp = t;
		e.event_ref = handle;
		e.message_tag = tag;
		e.end_of_message = eom;
		return e;
	endfunction

	function automatic plan_row_t cfg_row(input stamp_t s, input stamp_t r, input rcnt_t k);
		plan_row_t p;
		p = '0;
		p.kind = ROW_CFG;
		p.slide = s;
		p.win_range = r;
		p.ranks = k;
		return p;
	endfunction

	function automatic plan_row_t pred_row(input swea_pkg::evt_item_t e);
		plan_row_t p;
		p = '0;
		p.kind = ROW_PRED;
		p.ev = e;
		return p;
	endfunction

	function automatic plan_row_t typed_row(input swea_pkg::evt_item_t e, input logic has_win,
			input stamp_t win, input rank_t rank, input stamp_t lo, input stamp_t hi);
		plan_row_t p;
		p = '0;
		p.kind = ROW_TYPED;
		p.ev = e;
		p.has_win = has_win;
		p.win = win;
		p.rank = rank;
		p.lo = lo;
		p.hi = hi;
		return p;
	endfunction

	function automatic void add_row(input plan_row_t p);
		plan[n_plan] = p;
		n_plan++;
	endfunction

	function automatic void step_add(input swea_pkg::res_item_t x);
		step_res[step_n] = x;
		step_n++;
	endfunction

	function automatic string show_result(input swea_pkg::res_item_t x);
		return $sformatf("kind %0d win %0h rank %0h ref %h tag %0h lo %0h hi %0h last %0d",
			x.result_kind, x.window_id, x.target_rank, x.out_event_ref, x.out_message_tag,
			x.span_low, x.span_high, x.last);
	endfunction

	// windows of one event, oldest first, then the message summary on end of message
	task automatic assign_windows(input swea_pkg::evt_item_t e);
		stamp_t slide;
		stamp_t newest;
		stamp_t cnt;
		stamp_t back;
		stamp_t oldest;
		rcnt_t ranks;
		logic [31:0] w;
		swea_pkg::res_item_t r;
		step_n = 0;
		slide = (cfg_slide == '0) ? stamp_t'(1) : cfg_slide;
		ranks = (cfg_ranks > swea_pkg::RANK_LIMIT) ? swea_pkg::RANK_LIMIT : cfg_ranks;
		newest = e.evt_stamp / slide;
		cnt = cfg_range / slide;
		if (cnt > swea_pkg::MAX_WINDOWS_PER_EVENT) begin
			cnt = stamp_t'(swea_pkg::MAX_WINDOWS_PER_EVENT);
		end
		if (cnt != '0) begin
			back = cnt - stamp_t'(1);
			oldest = newest - ((back < newest) ? back : newest);
			if (newest > span_hi) begin
				span_hi = newest;
			end
			if (oldest < span_lo) begin
				span_lo = oldest;
			end
			for (w = 32'(oldest); w <= 32'(newest); w++) begin
				r = '0;
				r.result_kind = swea_pkg::KIND_ASSIGN;
				r.window_id = w[swea_pkg::TIME_W-1:0];
				r.target_rank = (ranks == '0) ? '0 : rank_t'(w % ranks);
				r.out_event_ref = e.event_ref;
				r.out_message_tag = e.message_tag;
				r.last = (w == 32'(newest)) && !e.end_of_message;
				step_add(r);
			end
		end
		if (e.end_of_message) begin
			r = '0;
			r.result_kind = swea_pkg::KIND_SUMMARY;
			r.out_message_tag = e.message_tag;
			r.span_low = span_lo;
			r.span_high = span_hi;
			r.last = 1'b1;
			step_add(r);
			span_lo = SPAN_LOW_RESET;
			span_hi = '0;
		end
	endtask

	task automatic run_event(input plan_row_t p);
		int gap;
		int i;
		swea_pkg::res_item_t r;
		gap = tx_calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt <= p.ev;
		evt_valid <= 1'b1;
		@(posedge clk);
		while (!evt_ready) @(posedge clk);
		n_events++;
		assign_windows(p.ev);
		if (p.kind == ROW_TYPED) begin
			step_n = 0;
			if (p.has_win) begin
				r = '0;
				r.result_kind = swea_pkg::KIND_ASSIGN;
				r.window_id = p.win;
				r.target_rank = p.rank;
				r.out_event_ref = p.ev.event_ref;
				r.out_message_tag = p.ev.message_tag;
				r.last = !p.ev.end_of_message;
				step_add(r);
			end
			if (p.ev.end_of_message) begin
				r = '0;
				r.result_kind = swea_pkg::KIND_SUMMARY;
				r.out_message_tag = p.ev.message_tag;
				r.span_low = p.lo;
				r.span_high = p.hi;
				r.last = 1'b1;
				step_add(r);
			end
		end
		for (i = 0; i < step_n; i++) begin
			expected_res[exp_wr] = step_res[i];
			exp_wr++;
		end
	endtask

	task automatic wait_idle();
		evt_valid <= 1'b0;
		while (exp_rd != exp_wr) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [swea_pkg::DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= swea_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// unused upper data bits carry random values
	task automatic apply_settings(input stamp_t s, input stamp_t r, input rcnt_t k);
		wait_idle();
		reg_write(swea_pkg::REG_SLIDE, {1'($urandom_range(0, 1)), s});
		reg_write(swea_pkg::REG_RANGE, {1'($urandom_range(0, 1)), r});
		reg_write(swea_pkg::REG_RANKS, {23'($urandom()), k});
		cfg_slide = s;
		cfg_range = r;
		cfg_ranks = k;
		n_settings++;
	endtask

	// receiver: random stalls, calm stretches, one long hold-off
	initial begin
		int gap;
		int taken;
		bit calm;
		bit held;
		taken = 0;
		calm = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 50 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			gap = calm ? 0 : $urandom_range(0, 6);
			if (!held && taken == HOLD_AT) begin
				held = 1'b1;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			taken++;
		end
	end

	always @(posedge clk) begin
		swea_pkg::res_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (exp_rd == exp_wr) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: %s", show_result(res));
				end
			end else begin
				want = expected_res[exp_rd];
				exp_rd++;
				n_checked++;
				if (res.result_kind == swea_pkg::KIND_SUMMARY) begin
					n_summaries++;
				end
				if (res.result_kind !== want.result_kind || res.window_id !== want.window_id ||
						res.target_rank !== want.target_rank ||
						res.out_event_ref !== want.out_event_ref ||
						res.out_message_tag !== want.out_message_tag ||
						res.span_low !== want.span_low || res.span_high !== want.span_high ||
						res.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d mismatch", n_checked);
						$display("  expected %s", show_result(want));
						$display("  actual   %s", show_result(res));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("sliding_window_event_assigner_core_tb: done, errors");
			$finish;
		end
	end

	initial begin
		swea_pkg::evt_item_t e;
		stamp_t s;
		stamp_t r;
		stamp_t t;
		tag_t tag;
		rcnt_t k;
		int unsigned se;
		int ph;
		int sent;
		int len;
		int j;
		int i;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one window per event, equal to the timestamp, rank 0
		add_row(typed_row(mk_evt('0, '0, '0, 1'b0), 1'b1, '0, '0, '0, '0));
		add_row(typed_row(mk_evt(T_MAX, '1, '1, 1'b1), 1'b1, T_MAX, '0, '0, T_MAX));
		add_row(typed_row(mk_evt(stamp_t'(5), 32'h5a5a_a5a5, 31'h2aaa_5555, 1'b1), 1'b1,
			stamp_t'(5), '0, stamp_t'(5), stamp_t'(5)));
		// zero slide, zero range, zero ranks: nothing assigned, empty message summary
		add_row(cfg_row('0, '0, '0));
		add_row(typed_row(mk_evt(stamp_t'(100), 32'h1234_5678, tag_t'(9), 1'b0), 1'b0,
			'0, '0, '0, '0));
		add_row(typed_row(mk_evt(stamp_t'(100), 32'h8765_4321, tag_t'(9), 1'b1), 1'b0,
			'0, '0, SPAN_LOW_RESET, '0));
		// saturated count, oldest window clipped at zero
		add_row(cfg_row(stamp_t'(10), stamp_t'(320), rcnt_t'(7)));
		add_row(pred_row(mk_evt(stamp_t'(5), $urandom(), tag_t'(11), 1'b0)));
		add_row(pred_row(mk_evt(stamp_t'(1000), $urandom(), tag_t'(11), 1'b1)));
		add_row(cfg_row(stamp_t'(1), T_MAX, rcnt_t'(300)));
		add_row(pred_row(mk_evt(T_MAX, $urandom(), tag_t'(12), 1'b0)));
		add_row(pred_row(mk_evt(stamp_t'(31), $urandom(), tag_t'(12), 1'b1)));
		add_row(pred_row(mk_evt(stamp_t'(30), $urandom(), tag_t'(13), 1'b0)));
		add_row(pred_row(mk_evt('0, $urandom(), tag_t'(13), 1'b1)));
		// largest slide and range: a single window, 0 or 1
		add_row(cfg_row(T_MAX, T_MAX, rcnt_t'(256)));
		add_row(typed_row(mk_evt(T_MAX - stamp_t'(1), 32'hffff_0000, tag_t'(14), 1'b0), 1'b1,
			'0, '0, '0, '0));
		add_row(typed_row(mk_evt(T_MAX, 32'h0000_ffff, tag_t'(14), 1'b1), 1'b1,
			stamp_t'(1), rank_t'(1), '0, stamp_t'(1)));
		// range shorter than slide, rank count above the limit
		add_row(cfg_row(stamp_t'(7), stamp_t'(3), rcnt_t'(511)));
		add_row(typed_row(mk_evt(stamp_t'(50), 32'hdead_beef, tag_t'(15), 1'b1), 1'b0,
			'0, '0, SPAN_LOW_RESET, '0));
		add_row(cfg_row(stamp_t'(3), stamp_t'(100), rcnt_t'(1)));
		add_row(pred_row(mk_evt(stamp_t'(200), $urandom(), tag_t'(16), 1'b0)));
		add_row(pred_row(mk_evt(stamp_t'(9), $urandom(), tag_t'(16), 1'b1)));

		for (i = 0; i < n_plan; i++) begin
			if (plan[i].kind == ROW_CFG) begin
				apply_settings(plan[i].slide, plan[i].win_range, plan[i].ranks);
			end else begin
				run_event(plan[i]);
			end
		end

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			s = ($urandom_range(0, 4) == 0) ? stamp_t'($urandom()) : stamp_t'($urandom_range(0, 12));
			se = (s == '0) ? 1 : 32'(s);
			if (se <= 12) begin
				r = stamp_t'(se * $urandom_range(0, 36) + $urandom_range(0, se - 1));
			end else begin
				r = ($urandom_range(0, 1) == 0) ? (s >> 1) : stamp_t'($urandom());
			end
			k = ($urandom_range(0, 3) == 0) ? rcnt_t'($urandom_range(0, 511)) :
				rcnt_t'($urandom_range(1, 16));
			apply_settings(s, r, k);
			tx_calm = ($urandom_range(0, 3) == 0);
			sent = 0;
			while (sent < PHASE_EVENTS) begin
				len = $urandom_range(1, 6);
				tag = tag_t'($urandom());
				t = ($urandom_range(0, 2) == 0) ? stamp_t'($urandom_range(0, 300)) : stamp_t'($urandom());
				for (j = 0; j < len && sent < PHASE_EVENTS; j++) begin
					e = mk_evt(t, $urandom(), tag, j == len - 1);
					// noise: stray event with its own tag and random end flag
					if ($urandom_range(0, 7) == 0) begin
						e = mk_evt(stamp_t'($urandom()), $urandom(), tag_t'($urandom()),
							1'($urandom_range(0, 1)));
					end
					run_event(pred_row(e));
					sent++;
					t = t + stamp_t'($urandom_range(0, 40));
				end
			end
		end

		wait_idle();
		$display("covered %0d events over %0d register settings, %0d results checked",
			n_events, n_settings, n_checked);
		$display("%0d message summaries, one receiver hold-off of %0d cycles",
			n_summaries, HOLD_CYCLES);
		if (mismatches == 0 && exp_rd == exp_wr) begin
			$display("sliding_window_event_assigner_core_tb: done, clean");
		end else begin
			$display("sliding_window_event_assigner_core_tb: done, errors");
		end
		$finish;
	end

endmodule
